/* rtl/pinned_slot_cache_lru_unit_defines.svh */
// ----------------------------------------------------------------------------
// pinned slot cache assertion macros
// shared property forms for the cache control checks
// ----------------------------------------------------------------------------
`ifndef PINNED_SLOT_CACHE_LRU_UNIT_DEFINES_SVH
`define PINNED_SLOT_CACHE_LRU_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define PSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define PSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/psc_pkg.sv */
// ----------------------------------------------------------------------------
// psc_pkg
// shared types and constants of the pinned slot cache
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int SLOT_W      = 8;
  localparam int LAYER_W     = 8;
  localparam int EXPERT_W    = 10;
  localparam int PIN_W       = 8;
  localparam int STAMP_W     = 64;
  localparam int CFG_W       = 5;
  localparam int CNT_W       = 9;   // holds an enabled-slot count up to 256
  localparam int STAT_W      = 32;

  // entry update issued to one cell
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_HIT,
    CMD_ALLOC,
    CMD_REL,
    CMD_DONE,
    CMD_FAIL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [SLOT_W-1:0]     idx;
    logic [LAYER_W-1:0]    layer;
    logic [EXPERT_W-1:0]   expert;
    logic [STAMP_W-1:0]    stamp;
  } cmd_t;

  // search record carried from cell to cell
  typedef struct packed {
    logic [LAYER_W-1:0]    layer;
    logic [EXPERT_W-1:0]   expert;
    logic                  matched;
    logic [SLOT_W-1:0]     match_i;
    logic                  match_loading;
    logic                  have_empty;
    logic [SLOT_W-1:0]     empty_i;
    logic                  have_lru;
    logic [SLOT_W-1:0]     lru_i;
    logic [STAMP_W-1:0]    lru_stamp;
    logic                  lru_valid;
    logic [LAYER_W-1:0]    lru_layer;
    logic [EXPERT_W-1:0]   lru_expert;
  } scan_rec_t;

endpackage

`default_nettype wire

/* rtl/pinned_slot_cache_lru_unit.sv */
// ----------------------------------------------------------------------------
// pinned_slot_cache_lru_unit
// fully associative slot cache with pin counts and lru replacement
// ----------------------------------------------------------------------------
// acquire: the search record walks the row of slot cells, one cell per cycle,
//   and the result is registered at the row end; busy holds off the next accept
// release, load done, load failed: S_EXEC, then a registered result; busy until then
// sync active-low reset clears all entries, tick and counters; cfg resets to 16 slots
// results are one-cycle strobes on out_valid; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none
`include "pinned_slot_cache_lru_unit_defines.svh"

module pinned_slot_cache_lru_unit #(
  parameter int SLOTS = psc_pkg::SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [psc_pkg::CFG_W-1:0]     cfg_wdata,
  // command beat
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_op,
  input  wire logic [psc_pkg::LAYER_W-1:0]   in_layer_tag,
  input  wire logic [psc_pkg::EXPERT_W-1:0]  in_expert_tag,
  input  wire logic [psc_pkg::SLOT_W-1:0]    in_slot_index,
  // result beat
  output logic                               out_valid,
  output logic [2:0]                         out_status,
  output logic [psc_pkg::SLOT_W-1:0]         out_slot,
  output logic                               out_evicted,
  output logic [psc_pkg::LAYER_W-1:0]        out_evicted_layer,
  output logic [psc_pkg::EXPERT_W-1:0]       out_evicted_expert,
  output logic [psc_pkg::STAT_W-1:0]         out_hit_count,
  output logic [psc_pkg::STAT_W-1:0]         out_miss_count,
  output logic [psc_pkg::STAT_W-1:0]         out_eviction_count
);
  import psc_pkg::*;

  // operation codes
  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_DONE    = 2'd2;

  // result status codes
  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_COALESCED = 3'd1;
  localparam logic [2:0] ST_MISS_LOAD = 3'd2;
  localparam logic [2:0] ST_NO_FREE   = 3'd3;
  localparam logic [2:0] ST_RELEASED  = 3'd4;
  localparam logic [2:0] ST_IGNORED   = 3'd5;
  localparam logic [2:0] ST_LOADED    = 3'd6;
  localparam logic [2:0] ST_CLEARED   = 3'd7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_t;

  state_t               state_r;
  logic [CFG_W-1:0]     cfg_r;
  logic [1:0]           op_r;
  logic [LAYER_W-1:0]   layer_r;
  logic [EXPERT_W-1:0]  expert_r;
  logic [SLOT_W-1:0]    sidx_r;
  logic [STAMP_W-1:0]   tick_r;
  logic [STAT_W-1:0]    hits_r, misses_r, evictions_r;

  logic                 out_valid_r;
  logic [2:0]           out_status_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_evicted_r;
  logic [LAYER_W-1:0]   out_ev_layer_r;
  logic [EXPERT_W-1:0]  out_ev_expert_r;

  logic                 accept;
  logic [CNT_W-1:0]     n_en;

  // chain wiring: entry k feeds cell k
  logic                 scan_vld [SLOTS+1];
  scan_rec_t            scan_rec [SLOTS+1];
  scan_rec_t            rec_init;
  scan_rec_t            rec_fin;
  logic                 scan_done;

  // commit decision
  cmd_t                 cmd;
  logic [2:0]           res_status;
  logic [SLOT_W-1:0]    res_slot;
  logic                 res_ev;
  logic [LAYER_W-1:0]   res_ev_layer;
  logic [EXPERT_W-1:0]  res_ev_expert;
  logic                 inc_hit, inc_miss, inc_ev;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // enabled slots: zero reads as one, clamp at SLOTS
  always_comb begin
    if (cfg_r == '0) begin
      n_en = CNT_W'(1);
    end else if (CNT_W'(cfg_r) > CNT_W'(SLOTS)) begin
      n_en = CNT_W'(SLOTS);
    end else begin
      n_en = CNT_W'(cfg_r);
    end
  end

  // fresh search record launched straight from the command ports
  always_comb begin
    rec_init        = '0;
    rec_init.layer  = in_layer_tag;
    rec_init.expert = in_expert_tag;
  end

  assign scan_vld[0] = accept && (in_op == OP_ACQUIRE);
  assign scan_rec[0] = rec_init;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    psc_cell #(
      .IDX (k)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .n_i        (n_en),
      .scan_vld_i (scan_vld[k]),
      .rec_i      (scan_rec[k]),
      .scan_vld_o (scan_vld[k+1]),
      .rec_o      (scan_rec[k+1]),
      .cmd_i      (cmd)
    );
  end

  assign scan_done = scan_vld[SLOTS];
  assign rec_fin   = scan_rec[SLOTS];

  // decide the result and the entry update for the beat in flight
  always_comb begin
    cmd           = '0;
    cmd.kind      = CMD_NONE;
    cmd.layer     = layer_r;
    cmd.expert    = expert_r;
    cmd.stamp     = tick_r;
    res_status    = ST_IGNORED;
    res_slot      = sidx_r;
    res_ev        = 1'b0;
    res_ev_layer  = '0;
    res_ev_expert = '0;
    inc_hit       = 1'b0;
    inc_miss      = 1'b0;
    inc_ev        = 1'b0;
    if (state_r == S_SCAN) begin
      if (rec_fin.matched) begin
        cmd.kind   = CMD_HIT;
        cmd.idx    = rec_fin.match_i;
        res_slot   = rec_fin.match_i;
        if (rec_fin.match_loading) begin
          res_status = ST_COALESCED;
          inc_miss   = 1'b1;
        end else begin
          res_status = ST_HIT;
          inc_hit    = 1'b1;
        end
      end else begin
        inc_miss = 1'b1;
        if (rec_fin.have_empty) begin
          cmd.kind   = CMD_ALLOC;
          cmd.idx    = rec_fin.empty_i;
          res_slot   = rec_fin.empty_i;
          res_status = ST_MISS_LOAD;
        end else if (rec_fin.have_lru) begin
          cmd.kind   = CMD_ALLOC;
          cmd.idx    = rec_fin.lru_i;
          res_slot   = rec_fin.lru_i;
          res_status = ST_MISS_LOAD;
          if (rec_fin.lru_valid) begin
            res_ev        = 1'b1;
            res_ev_layer  = rec_fin.lru_layer;
            res_ev_expert = rec_fin.lru_expert;
            inc_ev        = 1'b1;
          end
        end else begin
          res_status = ST_NO_FREE;
          res_slot   = '0;
        end
      end
      if (!scan_done) begin
        cmd.kind = CMD_NONE;
      end
    end else if (state_r == S_EXEC) begin
      cmd.idx = sidx_r;
      if (CNT_W'(sidx_r) < n_en) begin
        case (op_r)
          OP_RELEASE: begin
            cmd.kind   = CMD_REL;
            res_status = ST_RELEASED;
          end
          OP_DONE: begin
            cmd.kind   = CMD_DONE;
            res_status = ST_LOADED;
          end
          default: begin
            cmd.kind   = CMD_FAIL;
            res_status = ST_CLEARED;
          end
        endcase
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_W'(SLOTS_DEF);
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      layer_r  <= in_layer_tag;
      expert_r <= in_expert_tag;
      sidx_r   <= in_slot_index;
    end
  end

  // sequencer, tick, counters and result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      tick_r          <= '0;
      hits_r          <= '0;
      misses_r        <= '0;
      evictions_r     <= '0;
      out_valid_r     <= 1'b0;
      out_status_r    <= '0;
      out_slot_r      <= '0;
      out_evicted_r   <= 1'b0;
      out_ev_layer_r  <= '0;
      out_ev_expert_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          out_valid_r <= 1'b0;
          if (accept) begin
            if (in_op == OP_ACQUIRE) begin
              tick_r  <= tick_r + STAMP_W'(1);
              state_r <= S_SCAN;
            end else begin
              state_r <= S_EXEC;
            end
          end
        end
        S_SCAN, S_EXEC: begin
          if (state_r == S_EXEC || scan_done) begin
            state_r         <= S_IDLE;
            out_valid_r     <= 1'b1;
            out_status_r    <= res_status;
            out_slot_r      <= res_slot;
            out_evicted_r   <= res_ev;
            out_ev_layer_r  <= res_ev_layer;
            out_ev_expert_r <= res_ev_expert;
            if (inc_hit)  hits_r      <= hits_r + STAT_W'(1);
            if (inc_miss) misses_r    <= misses_r + STAT_W'(1);
            if (inc_ev)   evictions_r <= evictions_r + STAT_W'(1);
          end else begin
            out_valid_r <= 1'b0;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot           = out_slot_r;
  assign out_evicted        = out_evicted_r;
  assign out_evicted_layer  = out_ev_layer_r;
  assign out_evicted_expert = out_ev_expert_r;
  assign out_hit_count      = hits_r;
  assign out_miss_count     = misses_r;
  assign out_eviction_count = evictions_r;

  // the search record only reaches the row end while an acquire is scanning
  `PSC_ASSERT_NOW(a_scan_in_scan, scan_done, state_r == S_SCAN, "scan end outside scan")
  // a result beat always leaves the block idle
  `PSC_ASSERT_NOW(a_strobe_idle, out_valid_r, state_r == S_IDLE, "result while busy")
  // an accepted beat never produces a result in the very next cycle
  `PSC_ASSERT_NEXT(a_no_early_result, accept, !out_valid_r, "result too early")
  // eviction only ever comes with a miss that loaded
  `PSC_ASSERT_NOW(a_evict_miss, out_valid_r && out_evicted_r,
                  out_status_r == ST_MISS_LOAD, "eviction without miss load")

endmodule

`default_nettype wire

/* rtl/psc_cell.sv */
// ----------------------------------------------------------------------------
// psc_cell
// one cache slot: holds the entry and folds it into the passing search record
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psc_cell #(
  parameter int IDX = 0
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [psc_pkg::CNT_W-1:0] n_i,
  input  wire logic                     scan_vld_i,
  input  wire psc_pkg::scan_rec_t       rec_i,
  output logic                          scan_vld_o,
  output psc_pkg::scan_rec_t            rec_o,
  input  wire psc_pkg::cmd_t            cmd_i
);
  import psc_pkg::*;

  logic                 valid_r,   valid_nxt;
  logic [LAYER_W-1:0]   layer_r,   layer_nxt;
  logic [EXPERT_W-1:0]  expert_r,  expert_nxt;
  logic [PIN_W-1:0]     pin_r,     pin_nxt;
  logic                 loading_r, loading_nxt;
  logic [STAMP_W-1:0]   stamp_r,   stamp_nxt;
  logic                 scan_vld_r;
  scan_rec_t            rec_r,     rec_nxt;

  logic enabled;
  logic is_free;

  assign enabled = (CNT_W'(IDX) < n_i);
  assign is_free = (pin_r == '0) && !loading_r;

  // fold this slot into the search record
  always_comb begin
    rec_nxt = rec_i;
    if (enabled) begin
      if (!rec_i.matched && valid_r && layer_r == rec_i.layer &&
          expert_r == rec_i.expert) begin
        rec_nxt.matched       = 1'b1;
        rec_nxt.match_i       = SLOT_W'(IDX);
        rec_nxt.match_loading = loading_r;
      end
      if (!rec_i.have_empty && !valid_r && is_free) begin
        rec_nxt.have_empty = 1'b1;
        rec_nxt.empty_i    = SLOT_W'(IDX);
      end
      if (is_free && (!rec_i.have_lru || stamp_r < rec_i.lru_stamp)) begin
        rec_nxt.have_lru   = 1'b1;
        rec_nxt.lru_i      = SLOT_W'(IDX);
        rec_nxt.lru_stamp  = stamp_r;
        rec_nxt.lru_valid  = valid_r;
        rec_nxt.lru_layer  = layer_r;
        rec_nxt.lru_expert = expert_r;
      end
    end
  end

  // entry update when addressed
  always_comb begin
    valid_nxt   = valid_r;
    layer_nxt   = layer_r;
    expert_nxt  = expert_r;
    pin_nxt     = pin_r;
    loading_nxt = loading_r;
    stamp_nxt   = stamp_r;
    if (cmd_i.kind != CMD_NONE && cmd_i.idx == SLOT_W'(IDX)) begin
      case (cmd_i.kind)
        CMD_HIT: begin
          stamp_nxt = cmd_i.stamp;
          if (pin_r != '1) pin_nxt = pin_r + PIN_W'(1);
        end
        CMD_ALLOC: begin
          valid_nxt   = 1'b1;
          layer_nxt   = cmd_i.layer;
          expert_nxt  = cmd_i.expert;
          stamp_nxt   = cmd_i.stamp;
          pin_nxt     = PIN_W'(1);
          loading_nxt = 1'b1;
        end
        CMD_REL: begin
          if (pin_r != '0) pin_nxt = pin_r - PIN_W'(1);
        end
        CMD_DONE: begin
          loading_nxt = 1'b0;
        end
        CMD_FAIL: begin
          valid_nxt   = 1'b0;
          layer_nxt   = '0;
          expert_nxt  = '0;
          pin_nxt     = '0;
          loading_nxt = 1'b0;
        end
        default: begin
          valid_nxt = valid_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      layer_r    <= '0;
      expert_r   <= '0;
      pin_r      <= '0;
      loading_r  <= 1'b0;
      stamp_r    <= '0;
      scan_vld_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      layer_r    <= layer_nxt;
      expert_r   <= expert_nxt;
      pin_r      <= pin_nxt;
      loading_r  <= loading_nxt;
      stamp_r    <= stamp_nxt;
      scan_vld_r <= scan_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign scan_vld_o = scan_vld_r;
  assign rec_o      = rec_r;

endmodule

`default_nettype wire
